@@ rtl/bli_pkg.sv @@
`timescale 1ns / 1ps

package bli_pkg;

	// Width of the dwell register.
	localparam int unsigned DWELL_WIDTH = 16;

	// Dwell time after reset, in milliseconds.
	localparam logic [DWELL_WIDTH-1:0] DWELL_RESET = 16'd2000;

	// Sensor levels of one poll.
	typedef struct packed {
		logic entrance_loop;
		logic exit_loop;
		logic ticket_level;
		logic money_level;
	} bli_levels_t;

	// Outputs of one poll.
	typedef struct packed {
		logic entrance_request;
		logic exit_request;
		logic hold_closed;
	} bli_result_t;

endpackage

@@ rtl/bli_if.sv @@
`timescale 1ns / 1ps

// Poll channel: one request carries the four sensor levels and a timestamp.
interface bli_in_if #(
	parameter int unsigned TIME_WIDTH = 32
) ();
	logic                  valid;
	logic                  ready;
	logic                  entrance_loop;
	logic                  exit_loop;
	logic                  ticket_level;
	logic                  money_level;
	logic [TIME_WIDTH-1:0] now_ms;

	modport source (output valid, entrance_loop, exit_loop, ticket_level, money_level,
		now_ms, input ready);
	modport sink (input valid, entrance_loop, exit_loop, ticket_level, money_level,
		now_ms, output ready);
endinterface

// Result channel: one request carries the outputs of one poll.
interface bli_out_if ();
	logic valid;
	logic ready;
	logic entrance_request;
	logic exit_request;
	logic hold_closed;

	modport source (output valid, entrance_request, exit_request, hold_closed,
		input ready);
	modport sink (input valid, entrance_request, exit_request, hold_closed,
		output ready);
endinterface

@@ rtl/bli_step.sv @@
`timescale 1ns / 1ps

// Sequence state of the interlock and the combinational update for one poll.
// The state advances only when step_en is high.
module bli_step import bli_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step_en,
	input  bli_levels_t            levels,
	input  logic [TIME_WIDTH-1:0]  now_ms,
	input  logic [DWELL_WIDTH-1:0] dwell_ms,
	output bli_result_t            result
);

	typedef struct packed {
		logic prev_entrance;
		logic prev_exit;
		logic prev_ticket;
		logic prev_money;
		logic entrance_seen;
		logic exit_seen;
		logic ticket_seen;
		logic money_seen;
		logic entrance_timing;
		logic entrance_blocked;
		logic left_exit_loop;
		logic exit_active;
		logic exit_hold;
	} bli_flags_t;

	bli_flags_t            flags_q, flags_d;
	logic [TIME_WIDTH-1:0] start_time_q, start_time_d;
	logic                  ent_req, ext_req;

	always_comb begin
		logic was_active;
		flags_d      = flags_q;
		start_time_d = start_time_q;
		ent_req      = 1'b0;
		ext_req      = 1'b0;
		was_active   = flags_q.exit_active;

		if (levels.entrance_loop && !flags_q.prev_entrance) flags_d.entrance_seen = 1'b1;
		if (levels.exit_loop && !flags_q.prev_exit) flags_d.exit_seen = 1'b1;
		if (levels.ticket_level && !flags_q.prev_ticket) flags_d.ticket_seen = 1'b1;
		if (levels.money_level && !flags_q.prev_money) flags_d.money_seen = 1'b1;

		if (flags_d.entrance_blocked && !levels.exit_loop) begin
			flags_d.entrance_blocked = 1'b0;
			flags_d.left_exit_loop   = 1'b1;
		end

		if (flags_d.entrance_seen) begin
			if (levels.exit_loop) begin
				flags_d.entrance_blocked = 1'b1;
			end else begin
				flags_d.entrance_seen   = 1'b0;
				flags_d.left_exit_loop  = 1'b0;
				flags_d.entrance_timing = 1'b1;
				start_time_d            = now_ms;
			end
		end

		// A dwell started in this same poll sees an elapsed time of zero.
		// The elapsed time wraps with the timestamp width.
		if (flags_d.entrance_timing) begin
			if (!levels.entrance_loop) begin
				flags_d.entrance_timing = 1'b0;
			end else if ((now_ms - start_time_d) >
				TIME_WIDTH'(dwell_ms)) begin
				flags_d.entrance_timing = 1'b0;
				ent_req                 = 1'b1;
			end
		end

		if (flags_d.exit_hold && was_active && !levels.entrance_loop) begin
			flags_d.exit_hold = 1'b0;
			ext_req           = 1'b1;
		end

		if (was_active) begin
			if (!levels.exit_loop) flags_d.exit_active = 1'b0;
			if (flags_d.ticket_seen || flags_d.money_seen) begin
				flags_d.ticket_seen = 1'b0;
				flags_d.money_seen  = 1'b0;
				flags_d.exit_hold   = 1'b1;
			end
		end

		if (flags_d.exit_seen) begin
			flags_d.exit_active = 1'b1;
			flags_d.exit_seen   = 1'b0;
		end

		flags_d.prev_entrance = levels.entrance_loop;
		flags_d.prev_exit     = levels.exit_loop;
		flags_d.prev_ticket   = levels.ticket_level;
		flags_d.prev_money    = levels.money_level;
	end

	assign result.entrance_request = ent_req;
	assign result.exit_request     = ext_req;
	assign result.hold_closed      = levels.entrance_loop && levels.exit_loop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			start_time_q <= '0;
		end else if (step_en) begin
			flags_q      <= flags_d;
			start_time_q <= start_time_d;
		end
	end

endmodule

@@ rtl/barrier_loop_interlock.sv @@
`timescale 1ns / 1ps

// Parking barrier interlock.
// Each request on the sensor channel is one poll of the entrance loop, the exit
// loop, the ticket reader and the payment input, together with a millisecond
// timestamp. For every poll exactly one request leaves on the result channel,
// in order, carrying the entrance request pulse, the exit request pulse and
// the hold-closed level.
// The poll is captured in an input register, the sequence logic works on it
// combinationally and the outcome lands in the result register, from which it
// leaves on the result channel. A new poll can be taken every cycle while the
// receiver keeps taking results.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more poll, after which the sensor channel
// stops taking polls until the result is taken.
// Reset clears all sequence flags, the dwell start time and both pipeline
// stages, and sets the dwell time to 2000 ms. The dwell register may be
// written through cfg_we and cfg_wdata while no poll is in flight.
module barrier_loop_interlock import bli_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [DWELL_WIDTH-1:0] cfg_wdata,
	bli_in_if.sink                 sensor,
	bli_out_if.source              result
);

	logic [DWELL_WIDTH-1:0] dwell_q;

	logic                  valid_s1;
	bli_levels_t           levels_s1;
	logic [TIME_WIDTH-1:0] now_s1;

	logic                  valid_s2;
	bli_result_t           res_s2;

	bli_result_t           step_res;
	logic                  advance;

	// The poll in the input register moves on when the result register is free
	// or is being emptied in this cycle.
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sensor.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= DWELL_RESET;
		end else if (cfg_we) begin
			dwell_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			levels_s1.entrance_loop <= sensor.entrance_loop;
			levels_s1.exit_loop     <= sensor.exit_loop;
			levels_s1.ticket_level  <= sensor.ticket_level;
			levels_s1.money_level   <= sensor.money_level;
			now_s1                  <= sensor.now_ms;
		end
	end

	// The sequence state updates exactly once per poll, as it moves on.
	bli_step #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.levels   (levels_s1),
		.now_ms   (now_s1),
		.dwell_ms (dwell_q),
		.result   (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign result.valid            = valid_s2;
	assign result.entrance_request = res_s2.entrance_request;
	assign result.exit_request     = res_s2.exit_request;
	assign result.hold_closed      = res_s2.hold_closed;

endmodule

@@ rtl/bli_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks of the interlock.
module bli_checker import bli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_entrance_request,
	input logic out_exit_request,
	input logic out_hold_closed
);

	logic [1:0] inflight_q;
	logic       last_ent_q;
	logic       in_take, out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
			last_ent_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 2'(in_take) - 2'(out_take);
			if (out_take) last_ent_q <= out_entrance_request;
		end
	end

	// A stalled result request keeps its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_entrance_request)
		&& $stable(out_exit_request) && $stable(out_hold_closed))
		else $error("result changed while stalled");

	// No more than two polls are ever held inside the block.
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2)
		else $error("more than two polls in flight");

	// A result is only shown for a poll that was taken.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 2'd0)
		else $error("result without a poll");

	// With the result register empty, the sensor channel is always open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("sensor channel closed while result register empty");

	// An entrance request ends the dwell, so the next result cannot repeat it.
	a_ent_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_ent_q |-> !out_entrance_request)
		else $error("entrance request on two results in a row");

endmodule

bind barrier_loop_interlock bli_checker u_bli_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.in_valid             (sensor.valid),
	.in_ready             (sensor.ready),
	.out_valid            (result.valid),
	.out_ready            (result.ready),
	.out_entrance_request (result.entrance_request),
	.out_exit_request     (result.exit_request),
	.out_hold_closed      (result.hold_closed)
);
